// File: design/scrk_pkg.sv
// ----------------------------------------------------------------------------
// scrk_pkg: shared constants and functions
// Feedback taps, filter tables and byte-reversal helpers for the
// cipher state rollback and key recovery core.
// ----------------------------------------------------------------------------
package scrk_pkg;

  localparam int StateW = 48;
  localparam int WordW  = 32;
  localparam int KeySteps = 32;

  // feedback taps of one rollback step
  localparam logic [StateW-1:0] FbTaps = 48'hE700_2260_80E6;

  localparam logic [15:0] TabFa = 16'b0010_1100_0111_1001;
  localparam logic [15:0] TabFb = 16'b0110_0110_0111_0001;
  localparam logic [31:0] TabFc = 32'b0111_1001_0000_0111_0010_1000_0111_1011;

  // configuration register indexes
  localparam logic [4:0] CfgTagUid     = 5'd0;
  localparam logic [4:0] CfgReaderNonce = 5'd1;

  function automatic logic [7:0] rev8(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = b[i];
    end
    return r;
  endfunction

  function automatic logic [WordW-1:0] rev_bytes32(input logic [WordW-1:0] v);
    logic [WordW-1:0] r;
    for (int i = 0; i < 4; i++) begin
      r[8*i +: 8] = rev8(v[8*i +: 8]);
    end
    return r;
  endfunction

  function automatic logic [StateW-1:0] rev_bytes48(input logic [StateW-1:0] v);
    logic [StateW-1:0] r;
    for (int i = 0; i < 6; i++) begin
      r[8*i +: 8] = rev8(v[8*i +: 8]);
    end
    return r;
  endfunction

  function automatic logic filter_bit(input logic [StateW-1:0] s);
    logic a0, b0, b1, b2, a1;
    a0 = TabFa[{s[5], s[4], s[2], s[1]}];
    b0 = TabFb[{s[14], s[13], s[11], s[7]}];
    b1 = TabFb[{s[25], s[22], s[20], s[16]}];
    b2 = TabFb[{s[32], s[30], s[28], s[27]}];
    a1 = TabFa[{s[45], s[43], s[42], s[33]}];
    return TabFc[{a1, b2, b1, b0, a0}];
  endfunction

endpackage

// File: design/scrk_shift_unit.sv
// ----------------------------------------------------------------------------
// scrk_shift_unit: shared state shifter
// Holds the 48-bit cipher state and moves it one step per cycle while a step is requested,
// either a linear rollback step or a key step that feeds the identifier bit in.
// ----------------------------------------------------------------------------
module scrk_shift_unit (
  input  logic                          clk,
  input  logic                          load,
  input  logic [scrk_pkg::StateW-1:0]   load_state,
  input  logic                          roll_step,
  input  logic                          key_step,
  input  logic                          uid_bit,
  input  logic                          nonce_bit,
  output logic [scrk_pkg::StateW-1:0]   state,
  output logic                          key_bit
);

  logic lin_fb;

  assign lin_fb  = ^(state & scrk_pkg::FbTaps);
  assign key_bit = scrk_pkg::filter_bit(state) ^ state[scrk_pkg::StateW-1] ^ nonce_bit;

  always_ff @(posedge clk) begin
    if (load) begin
      state <= load_state;
    end else if (roll_step) begin
      state <= {state[scrk_pkg::StateW-2:0], lin_fb};
    end else if (key_step) begin
      state <= {state[scrk_pkg::StateW-2:0], uid_bit};
    end
  end

endmodule

// File: design/scrk_sequencer.sv
// ----------------------------------------------------------------------------
// scrk_sequencer: step sequencer
// Counts rollback steps, then 32 key steps, and collects key bits,
// identifier and nonce words as the shared unit runs.
// ----------------------------------------------------------------------------
module scrk_sequencer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [7:0]                    steps,
  input  logic [scrk_pkg::WordW-1:0]    uid_word,
  input  logic [scrk_pkg::WordW-1:0]    nonce_word,
  input  logic [scrk_pkg::StateW-1:0]   state,
  input  logic                          key_bit,
  output logic                          busy,
  output logic                          load,
  output logic                          roll_step,
  output logic                          key_step,
  output logic                          uid_bit,
  output logic                          nonce_bit,
  output logic                          done,
  output logic [scrk_pkg::StateW-1:0]   key_raw
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ROLL = 2'd1;
  localparam logic [1:0] S_KEY  = 2'd2;

  logic [1:0]                  fsm, fsm_next;
  logic [7:0]                  cnt;
  logic [scrk_pkg::WordW-1:0]  u, v, k;
  logic [15:0]                 low16;

  assign busy      = (fsm != S_IDLE);
  assign load      = start && !busy;
  assign roll_step = (fsm == S_ROLL) && (cnt != 8'd0);
  assign key_step  = (fsm == S_KEY);
  assign uid_bit   = u[scrk_pkg::WordW-1];
  assign nonce_bit = v[scrk_pkg::WordW-1];
  assign key_raw   = {k, low16};

  always_comb begin
    fsm_next = fsm;
    unique case (fsm)
      S_IDLE: if (load) fsm_next = S_ROLL;
      S_ROLL: if (cnt == 8'd0) fsm_next = S_KEY;
      S_KEY:  if (cnt == 8'(scrk_pkg::KeySteps - 1)) fsm_next = S_IDLE;
      default: fsm_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm  <= S_IDLE;
      done <= 1'b0;
    end else begin
      fsm  <= fsm_next;
      done <= key_step && (cnt == 8'(scrk_pkg::KeySteps - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cnt <= steps;
      u   <= uid_word;
      v   <= nonce_word;
    end else if (fsm == S_ROLL) begin
      if (cnt == 8'd0) begin
        // capture the rolled state's low half before key steps begin
        low16 <= state[15:0];
      end else begin
        cnt <= cnt - 8'd1;
      end
    end else if (key_step) begin
      k   <= {k[scrk_pkg::WordW-2:0], key_bit};
      u   <= {u[scrk_pkg::WordW-2:0], 1'b0};
      v   <= {v[scrk_pkg::WordW-2:0], 1'b0};
      cnt <= cnt + 8'd1;
    end
  end

endmodule

// File: design/stream_cipher_rollback_key_recovery_core.sv
// busy stays high from the accepting edge until done; start is not accepted while busy.
// Reset: synchronous, active high; clears the sequencer FSM and done flag and both config regs.
// The receiver cannot stall: recovered_key holds after done until the next job ends its rollback steps.
// ----------------------------------------------------------------------------
// stream_cipher_rollback_key_recovery_core: top level
// Rolls a cipher state back, runs 32 key steps and returns the key.
// ----------------------------------------------------------------------------
module stream_cipher_rollback_key_recovery_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [4:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         start,
  input  logic [47:0]  observed_state,
  input  logic [7:0]   rollback_steps,
  output logic         busy,
  output logic         done,
  output logic [47:0]  recovered_key
);

  logic [31:0] tag_uid, reader_nonce;
  logic        load, roll_step, key_step, uid_bit, nonce_bit, key_bit;
  logic [47:0] state, key_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_uid      <= '0;
      reader_nonce <= '0;
    end else if (cfg_we) begin
      if (cfg_index == scrk_pkg::CfgTagUid) tag_uid <= cfg_data;
      else if (cfg_index == scrk_pkg::CfgReaderNonce) reader_nonce <= cfg_data;
    end
  end

  scrk_sequencer u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .steps      (rollback_steps),
    .uid_word   (scrk_pkg::rev_bytes32(tag_uid)),
    .nonce_word (scrk_pkg::rev_bytes32(reader_nonce)),
    .state      (state),
    .key_bit    (key_bit),
    .busy       (busy),
    .load       (load),
    .roll_step  (roll_step),
    .key_step   (key_step),
    .uid_bit    (uid_bit),
    .nonce_bit  (nonce_bit),
    .done       (done),
    .key_raw    (key_raw)
  );

  scrk_shift_unit u_shift (
    .clk        (clk),
    .load       (load),
    .load_state (observed_state),
    .roll_step  (roll_step),
    .key_step   (key_step),
    .uid_bit    (uid_bit),
    .nonce_bit  (nonce_bit),
    .state      (state),
    .key_bit    (key_bit)
  );

  assign recovered_key = scrk_pkg::rev_bytes48(key_raw);

`ifndef SYNTHESIS
  a_done_ends_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("done without a finishing job");

  a_no_step_idle: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !roll_step && !key_step)
    else $error("shift unit stepping while idle");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");
`endif

endmodule

// File: tb/key_recovery_checker.sv
// ----------------------------------------------------------------------------
// key_recovery_checker: result predictor and scoreboard
// Tracks register writes, predicts the recovered key for every accepted job
// and compares each done strobe against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module key_recovery_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        start,
  input  logic        busy,
  input  logic [47:0] observed_state,
  input  logic [7:0]  rollback_steps,
  input  logic        done,
  input  logic [47:0] recovered_key,
  output int          keys_in_flight,
  output int          mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // entry i of each lookup sits at bit i
  localparam logic [15:0] NibLutA = 16'h2C79;
  localparam logic [15:0] NibLutB = 16'h6671;
  localparam logic [31:0] MixLut  = 32'h7907_287B;

  logic [31:0] uid_shadow;
  logic [31:0] nonce_shadow;
  logic [47:0] pending_keys[$];
  int          bad_results;

  function automatic logic [47:0] flip_each_byte(input logic [47:0] x);
    logic [47:0] y;
    for (int b = 0; b < 6; b++) begin
      for (int i = 0; i < 8; i++) begin
        y[8*b + 7 - i] = x[8*b + i];
      end
    end
    return y;
  endfunction

  function automatic logic rollback_parity(input logic [47:0] s);
    return s[1] ^ s[2] ^ s[5] ^ s[6] ^ s[7] ^ s[15] ^ s[21] ^ s[22] ^ s[25] ^
           s[29] ^ s[40] ^ s[41] ^ s[42] ^ s[45] ^ s[46] ^ s[47];
  endfunction

  function automatic logic keystream_bit(input logic [47:0] s);
    logic [4:0] sel;
    sel[0] = NibLutA[{s[5], s[4], s[2], s[1]}];
    sel[1] = NibLutB[{s[14], s[13], s[11], s[7]}];
    sel[2] = NibLutB[{s[25], s[22], s[20], s[16]}];
    sel[3] = NibLutB[{s[32], s[30], s[28], s[27]}];
    sel[4] = NibLutA[{s[45], s[43], s[42], s[33]}];
    return MixLut[sel];
  endfunction

  function automatic logic [47:0] predict_key(input logic [47:0] seed,
                                              input logic [7:0]  depth,
                                              input logic [31:0] uid,
                                              input logic [31:0] nonce);
    logic [47:0] s;
    logic [47:0] wide;
    logic [31:0] u;
    logic [31:0] v;
    logic [31:0] k;
    logic [15:0] low_half;
    s = seed;
    wide = flip_each_byte({16'h0000, uid});
    u = wide[31:0];
    wide = flip_each_byte({16'h0000, nonce});
    v = wide[31:0];
    k = '0;
    for (int j = 0; j < depth; j++) begin
      s = {s[46:0], rollback_parity(s)};
    end
    low_half = s[15:0];
    for (int j = 0; j < 32; j++) begin
      k = {k[30:0], keystream_bit(s) ^ s[47] ^ v[31]};
      s = {s[46:0], u[31]};
      u = u << 1;
      v = v << 1;
    end
    return flip_each_byte({k, low_half});
  endfunction

  always @(posedge clk) begin : track
    logic [47:0] want;
    if (rst) begin
      uid_shadow = '0;
      nonce_shadow = '0;
      pending_keys.delete();
      bad_results = 0;
    end else begin
      if (done) begin
        if (pending_keys.size() == 0) begin
          $display("%0t recovered_key unexpected: expected none got %012h",
                   $time, recovered_key);
          bad_results++;
        end else begin
          want = pending_keys.pop_front();
          if (recovered_key !== want) begin
            $display("%0t recovered_key mismatch: expected %012h got %012h",
                     $time, want, recovered_key);
            bad_results++;
          end
        end
      end
      // predict with the settings in force before any write at this edge
      if (start && !busy) begin
        pending_keys.push_back(predict_key(observed_state, rollback_steps,
                                           uid_shadow, nonce_shadow));
      end
      if (cfg_we) begin
        case (cfg_index)
          scrk_pkg::CfgTagUid:      uid_shadow = cfg_data;
          scrk_pkg::CfgReaderNonce: nonce_shadow = cfg_data;
          default: ;
        endcase
      end
    end
    keys_in_flight <= pending_keys.size();
    mismatch_count <= bad_results;
  end

endmodule

// File: tb/stream_cipher_rollback_key_recovery_core_test.sv
// ----------------------------------------------------------------------------
// stream_cipher_rollback_key_recovery_core_test: regression top
// Drives directed and random key recovery jobs under several tag/nonce
// settings and sender idle mixes; the checker scores every returned key.
// ----------------------------------------------------------------------------
module stream_cipher_rollback_key_recovery_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PhaseCount  = 9;
  localparam int PhaseJobs   = 150;
  localparam int SettleTicks = 300;
  localparam int StallLimit  = 4000;
  // indexes past the register list; writes there must change nothing
  localparam logic [4:0] CfgUnusedLo = 5'd2;
  localparam logic [4:0] CfgUnusedHi = 5'd31;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        start = 1'b0;
  logic [47:0] observed_state = '0;
  logic [7:0]  rollback_steps = '0;
  logic        busy;
  logic        done;
  logic [47:0] recovered_key;

  int keys_in_flight;
  int mismatch_count;
  int stall_ticks = 0;
  int jobs_sent = 0;
  int reg_writes = 0;
  int unused_writes = 0;
  int idle_pct = 0;
  int last_depth = 0;
  int min_depth = 255;
  int max_depth = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  stream_cipher_rollback_key_recovery_core uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .start(start),
    .observed_state(observed_state),
    .rollback_steps(rollback_steps),
    .busy(busy),
    .done(done),
    .recovered_key(recovered_key)
  );

  key_recovery_checker scoreboard (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .start(start),
    .busy(busy),
    .observed_state(observed_state),
    .rollback_steps(rollback_steps),
    .done(done),
    .recovered_key(recovered_key),
    .keys_in_flight(keys_in_flight),
    .mismatch_count(mismatch_count)
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) begin
      stall_ticks <= 0;
    end else if (stall_ticks >= StallLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_ticks <= stall_ticks + 1;
    end
  end

  task automatic write_reg(input logic [4:0] idx, input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    reg_writes++;
    if (idx != scrk_pkg::CfgTagUid && idx != scrk_pkg::CfgReaderNonce) unused_writes++;
  endtask

  // hold off until every predicted key has come back
  task automatic drain_jobs();
    start <= 1'b0;
    do @(posedge clk); while (keys_in_flight != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic run_job(input logic [47:0] st, input logic [7:0] depth);
    int gap;
    gap = 0;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      gap = $urandom_range(0, last_depth + 40);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    observed_state <= st;
    rollback_steps <= depth;
    do @(posedge clk); while (busy);
    last_depth = depth;
    jobs_sent++;
    if (depth < min_depth) min_depth = depth;
    if (depth > max_depth) max_depth = depth;
  endtask

  function automatic logic [47:0] pick_state();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return 48'h1 << $urandom_range(47);
      3: return ~(48'h1 << $urandom_range(47));
      default: return r[47:0];
    endcase
  endfunction

  // mostly shallow rollbacks keep the run short; deep ones still show up
  function automatic logic [7:0] pick_depth();
    int roll;
    roll = $urandom_range(99);
    if (roll < 3) return 8'd255;
    if (roll < 70) return 8'($urandom_range(0, 15));
    if (roll < 90) return 8'($urandom_range(16, 127));
    return 8'($urandom_range(128, 255));
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero tag and nonce straight out of reset
    run_job(48'h0, 8'd0);
    run_job(48'hFFFF_FFFF_FFFF, 8'd0);
    run_job(48'hFFFF_FFFF_FFFF, 8'd255);
    run_job(48'h0, 8'd255);
    run_job(48'h0123_4567_89AB, 8'd1);
    run_job(48'h8000_0000_0000, 8'h80);
    run_job(48'h0000_0000_0001, 8'h7F);
    drain_jobs();
    write_reg(scrk_pkg::CfgTagUid, 32'hFFFF_FFFF);
    run_job(48'h0, 8'd0);
    run_job(48'hFFFF_FFFF_FFFF, 8'd200);
    run_job(48'h5555_AAAA_5555, 8'd2);
    drain_jobs();
    write_reg(scrk_pkg::CfgReaderNonce, 32'hFFFF_FFFF);
    run_job(48'h0, 8'd0);
    run_job(48'hA5A5_5A5A_C3C3, 8'd17);
    drain_jobs();
    write_reg(scrk_pkg::CfgTagUid, 32'h1234_5678);
    write_reg(scrk_pkg::CfgReaderNonce, 32'h9ABC_DEF0);
    run_job(48'h0F0F_F0F0_3C3C, 8'd64);
    drain_jobs();
    // writes to unused indexes must leave both registers alone
    write_reg(CfgUnusedLo, 32'hFFFF_FFFF);
    write_reg(CfgUnusedHi, 32'h0000_0000);
    run_job(48'h0F0F_F0F0_3C3C, 8'd64);
    run_job(48'hFEDC_BA98_7654, 8'd9);

    for (int p = 0; p < PhaseCount; p++) begin
      drain_jobs();
      case (p % 3)
        0: idle_pct = 0;
        1: idle_pct = 68;
        default: idle_pct = 15;
      endcase
      if (p == 0) begin
        write_reg(scrk_pkg::CfgTagUid, 32'h0);
        write_reg(scrk_pkg::CfgReaderNonce, 32'hFFFF_FFFF);
      end else if (p == PhaseCount - 1) begin
        write_reg(scrk_pkg::CfgTagUid, 32'hFFFF_FFFF);
        write_reg(scrk_pkg::CfgReaderNonce, 32'h0);
      end else begin
        write_reg(scrk_pkg::CfgTagUid, pick_word());
        write_reg(scrk_pkg::CfgReaderNonce, pick_word());
      end
      if ($urandom_range(2) == 0) begin
        write_reg(5'($urandom_range(CfgUnusedLo, CfgUnusedHi)), $urandom);
      end
      for (int n = 0; n < PhaseJobs; n++) begin
        if ($urandom_range(49) == 0) drain_jobs();
        run_job(pick_state(), pick_depth());
      end
    end

    drain_jobs();
    repeat (SettleTicks) @(posedge clk);

    $display("Ran %0d key recovery jobs in %0d random phases after the directed set,",
             jobs_sent, PhaseCount);
    $display("rollback depth %0d..%0d, %0d register writes (%0d to unused indexes).",
             min_depth, max_depth, reg_writes, unused_writes);
    if (mismatch_count == 0 && keys_in_flight == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: sim.f
design/scrk_pkg.sv
design/scrk_shift_unit.sv
design/scrk_sequencer.sv
design/stream_cipher_rollback_key_recovery_core.sv
tb/key_recovery_checker.sv
tb/stream_cipher_rollback_key_recovery_core_test.sv
